[src/dhicc_pkg.sv]
// dhicc_pkg: shared constants for the direct hash insert collision count unit
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package dhicc_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned SIZE_W      = IDX_W + 1;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned STEP_W      = $clog2(KEY_W);
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned PROD_W      = KEY_W + FRAC_W;
  localparam int unsigned MPROD_W     = SIZE_W + FRAC_W;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // golden-ratio fraction (sqrt(5)-1)/2 as Q0.32
  localparam logic [FRAC_W-1:0] GOLDEN_Q32 = 32'h9E37_79B9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  // register index taken from paddr above the byte offset
  localparam logic REG_TABLE_SIZE = 1'b0;

endpackage

`default_nettype wire

[src/dhicc_if.sv]
// dhicc_key_if and dhicc_res_if: valid/ready channels for keys and results
// depends on dhicc_pkg for field widths
`default_nettype none

interface dhicc_key_if;
  logic                          valid;
  logic                          ready;
  logic [dhicc_pkg::KEY_W-1:0]   key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface dhicc_res_if;
  logic                          valid;
  logic                          ready;
  logic [dhicc_pkg::IDX_W-1:0]   div_index;
  logic                          div_collision;
  logic [dhicc_pkg::IDX_W-1:0]   mult_index;
  logic                          mult_collision;
  logic [dhicc_pkg::CNT_W-1:0]   div_total;
  logic [dhicc_pkg::CNT_W-1:0]   mult_total;

  modport source (output valid, output div_index, output div_collision, output mult_index,
                  output mult_collision, output div_total, output mult_total, input ready);
  modport sink   (input valid, input div_index, input div_collision, input mult_index,
                  input mult_collision, input div_total, input mult_total, output ready);
endinterface

`default_nettype wire

[src/direct_hash_insert_collision_count_unit.sv]
// sequence: a key transaction is followed by 31 remainder steps of the restoring
// bit-serial divider, one occupancy memory read, one write-back and output load
// one key at a time: a new key is taken only after the write-back loads the output
// reset: both 1024-entry occupancy memories are cleared one entry per cycle,
// during which no key is taken; totals zero, table_size 1024
// depends on dhicc_pkg and the channel interfaces in dhicc_if.sv
`default_nettype none

module direct_hash_insert_collision_count_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dhicc_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [dhicc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [dhicc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                     pready,
  dhicc_key_if.sink                                key_i,
  dhicc_res_if.source                              res_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]                          state_q, state_d;
  logic [dhicc_pkg::SIZE_W-1:0]        table_size_q;
  logic [dhicc_pkg::SIZE_W-1:0]        eff_size;
  logic [dhicc_pkg::SIZE_W-1:0]        size_q;
  logic [dhicc_pkg::KEY_W-1:0]         key_q;
  logic [dhicc_pkg::KEY_W-1:0]         dkey_q;
  logic [dhicc_pkg::IDX_W-1:0]         rem_q;
  logic [dhicc_pkg::SIZE_W-1:0]        rem_shift;
  logic [dhicc_pkg::SIZE_W-1:0]        rem_sub;
  logic [dhicc_pkg::STEP_W-1:0]        step_q;
  logic [dhicc_pkg::PROD_W-1:0]        frac_prod;
  logic [dhicc_pkg::FRAC_W-1:0]        frac_q;
  logic [dhicc_pkg::MPROD_W-1:0]       mult_prod;
  logic [dhicc_pkg::IDX_W-1:0]         midx_q;
  logic [dhicc_pkg::IDX_W-1:0]         clr_addr_q;
  logic [dhicc_pkg::CNT_W-1:0]         div_cnt_q, div_cnt_d;
  logic [dhicc_pkg::CNT_W-1:0]         mult_cnt_q, mult_cnt_d;
  logic                                res_valid_q;
  logic                                out_free;
  logic                                key_hs;
  logic                                cfg_wr;
  logic                                finish;

  // occupancy memories, one read port and one write port each
  logic                                div_mem  [dhicc_pkg::TABLE_DEPTH];
  logic                                mult_mem [dhicc_pkg::TABLE_DEPTH];
  logic                                div_rd_q, mult_rd_q;
  logic                                mem_we;
  logic                                mem_wdata;
  logic [dhicc_pkg::IDX_W-1:0]         div_waddr, mult_waddr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dhicc_pkg::REG_TABLE_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == dhicc_pkg::REG_TABLE_SIZE) begin
      prdata = dhicc_pkg::APB_DATA_W'(table_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= dhicc_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      table_size_q <= pwdata[dhicc_pkg::SIZE_W-1:0];
    end
  end

  // zero acts as one, anything above the depth acts as the depth
  always_comb begin
    eff_size = table_size_q;
    if (table_size_q == '0) begin
      eff_size = dhicc_pkg::SIZE_W'(1);
    end else if (table_size_q > dhicc_pkg::SIZE_RESET) begin
      eff_size = dhicc_pkg::SIZE_RESET;
    end
  end

  assign key_i.ready = (state_q == S_IDLE);
  assign key_hs      = key_i.valid && key_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign finish      = (state_q == S_WRITE) && out_free;

  // restoring remainder step, one key bit per cycle
  assign rem_shift = {rem_q, dkey_q[dhicc_pkg::KEY_W-1]};
  assign rem_sub   = rem_shift - size_q;

  assign frac_prod = dhicc_pkg::PROD_W'(key_q) * dhicc_pkg::PROD_W'(dhicc_pkg::GOLDEN_Q32);
  assign mult_prod = dhicc_pkg::MPROD_W'(size_q) * dhicc_pkg::MPROD_W'(frac_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (key_hs) state_d = S_DIV;
      end
      S_DIV: begin
        if (step_q == dhicc_pkg::STEP_W'(dhicc_pkg::KEY_W - 1)) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      step_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if (key_hs) begin
        step_q <= '0;
      end else if (state_q == S_DIV) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (key_hs) begin
      key_q  <= key_i.key;
      dkey_q <= key_i.key;
      size_q <= eff_size;
      rem_q  <= '0;
    end else if (state_q == S_DIV) begin
      dkey_q <= dkey_q << 1;
      if (rem_shift >= size_q) begin
        rem_q <= rem_sub[dhicc_pkg::IDX_W-1:0];
      end else begin
        rem_q <= rem_shift[dhicc_pkg::IDX_W-1:0];
      end
      // two-stage multiply settles long before the divider is done
      frac_q <= frac_prod[dhicc_pkg::FRAC_W-1:0];
      midx_q <= mult_prod[dhicc_pkg::FRAC_W +: dhicc_pkg::IDX_W];
    end
  end

  // memory write: clearing pass or marking the probed slots taken
  assign mem_we     = (state_q == S_CLEAR) || finish;
  assign mem_wdata  = (state_q != S_CLEAR);
  assign div_waddr  = (state_q == S_CLEAR) ? clr_addr_q : rem_q;
  assign mult_waddr = (state_q == S_CLEAR) ? clr_addr_q : midx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      div_mem[div_waddr]   <= mem_wdata;
      mult_mem[mult_waddr] <= mem_wdata;
    end
    if (state_q == S_READ) begin
      div_rd_q  <= div_mem[rem_q];
      mult_rd_q <= mult_mem[midx_q];
    end
  end

  // saturating totals
  always_comb begin
    div_cnt_d  = div_cnt_q;
    mult_cnt_d = mult_cnt_q;
    if (div_rd_q && (div_cnt_q != dhicc_pkg::CNT_MAX)) div_cnt_d = div_cnt_q + 1'b1;
    if (mult_rd_q && (mult_cnt_q != dhicc_pkg::CNT_MAX)) mult_cnt_d = mult_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q   <= '0;
      mult_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        div_cnt_q   <= div_cnt_d;
        mult_cnt_q  <= mult_cnt_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_o.div_index      <= rem_q;
      res_o.div_collision  <= div_rd_q;
      res_o.mult_index     <= midx_q;
      res_o.mult_collision <= mult_rd_q;
      res_o.div_total      <= div_cnt_d;
      res_o.mult_total     <= mult_cnt_d;
    end
  end

  assign res_o.valid = res_valid_q;

`ifndef SYNTH
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (dhicc_pkg::SIZE_W'(rem_q) < size_q))
    else $error("division index not below table size");

  a_midx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (dhicc_pkg::SIZE_W'(midx_q) < size_q))
    else $error("multiplication index not below table size");

  a_div_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (div_cnt_q >= $past(div_cnt_q)))
    else $error("division total decreased");

  a_result_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == S_WRITE))
    else $error("result loaded outside write-back");
`endif

endmodule

`default_nettype wire
